// File: rtl/core/bankers_safe_resource_grant_unit_defines.svh
// ----------------------------------------------------------------------------
// Banker's safe resource grant unit - assertion macros
// Clocked assertion wrappers on aclk; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BANKERS_SAFE_RESOURCE_GRANT_UNIT_DEFINES_SVH
`define BANKERS_SAFE_RESOURCE_GRANT_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BSRG_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("bsrg: assertion failed");
`define BSRG_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("bsrg: assertion failed");
`else
`define BSRG_ASSERT(label, prop)
`define BSRG_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: rtl/core/bsrg_pkg.sv
// ----------------------------------------------------------------------------
// Banker's safe resource grant unit - package
// Field widths, operation and status codes, FSM states, control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bsrg_pkg;

    localparam int MAX_PROCESSES_DEF = 16;
    localparam int MAX_RESOURCES_DEF = 4;
    localparam int COUNT_WIDTH_DEF   = 16;

    localparam int FUNC_W      = 2;
    localparam int PROC_W      = 4;
    localparam int RES_W       = 2;
    localparam int FIELD_W     = 16;
    localparam int REQ_FIELDS  = 4;
    localparam int STATUS_W    = 3;
    localparam int PCOUNT_W    = 5;
    localparam int RCOUNT_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 104;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd16;
    localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESOURCE_COUNT = 2'd1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET_TOTAL = 2'd0,
        FUNC_LOAD      = 2'd1,
        FUNC_REQUEST   = 2'd2,
        FUNC_RSVD      = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_OVER_NEED  = 3'd1,
        ST_OVER_AVAIL = 3'd2,
        ST_UNSAFE     = 3'd3,
        ST_LOAD_REJ   = 3'd4,
        ST_INACTIVE   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_LATCH,
        S_EXEC,
        S_SCAN_INIT,
        S_SCAN_RD,
        S_SCAN_EV,
        S_COMMIT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic latch;
        logic exec;
        logic scan_init;
        logic scan_step;
        logic scan_rd;
        logic scan_ev;
        logic commit;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_go;
        logic scan_end;
        logic scan_skip;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bsrg_ctrl.sv
// ----------------------------------------------------------------------------
// Banker's safe resource grant unit - controller
// Sequences fetch, execute, safety scan and result hand-off for one item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bankers_safe_resource_grant_unit_defines.svh"

module bsrg_ctrl
    import bsrg_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_FETCH;
            end
            S_FETCH:     state_next = S_LATCH;
            S_LATCH:     state_next = S_EXEC;
            S_EXEC: begin
                state_next = stat.scan_go ? S_SCAN_INIT : S_RESULT;
            end
            S_SCAN_INIT: state_next = S_SCAN_RD;
            S_SCAN_RD: begin
                if (stat.scan_end) begin
                    state_next = S_COMMIT;
                end else if (!stat.scan_skip) begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:   state_next = S_SCAN_RD;
            S_COMMIT:    state_next = S_RESULT;
            S_RESULT: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_FETCH:     ;
            S_LATCH:     cmd.latch = 1'b1;
            S_EXEC:      cmd.exec = 1'b1;
            S_SCAN_INIT: cmd.scan_init = 1'b1;
            S_SCAN_RD: begin
                cmd.scan_step = !stat.scan_end && stat.scan_skip;
                cmd.scan_rd   = !stat.scan_end && !stat.scan_skip;
            end
            S_SCAN_EV:   cmd.scan_ev = 1'b1;
            S_COMMIT:    cmd.commit = 1'b1;
            S_RESULT:    cmd.load_result = stat.out_free;
            default:     ;
        endcase
    end

    `BSRG_ASSERT(a_accept_closes_input, (s_tvalid && s_tready) |=> !s_tready)
    `BSRG_ASSERT(a_commit_after_scan, cmd.commit |-> $past(state_reg) == S_SCAN_RD)
    `BSRG_ASSERT(a_result_then_idle, cmd.load_result |=> s_tready)

endmodule

`default_nettype wire

// File: rtl/core/bsrg_datapath.sv
// ----------------------------------------------------------------------------
// Banker's safe resource grant unit - datapath
// Allocation/need row memories, available counts, safety scan and result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bankers_safe_resource_grant_unit_defines.svh"

module bsrg_datapath
    import bsrg_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire ctrl_cmd_t                          cmd,
    output dp_stat_t                                stat,
    input  wire logic [PCOUNT_W-1:0]                process_count,
    input  wire logic [RCOUNT_W-1:0]                resource_count,
    input  wire logic [FUNC_W-1:0]                  s_func,
    input  wire logic [PROC_W-1:0]                  s_process,
    input  wire logic [RES_W-1:0]                   s_resource,
    input  wire logic [FIELD_W-1:0]                 s_value_a,
    input  wire logic [FIELD_W-1:0]                 s_value_b,
    input  wire logic [REQ_FIELDS-1:0][FIELD_W-1:0] s_req,
    input  wire logic                               m_tready,
    output logic                                    m_tvalid,
    output logic [STATUS_W-1:0]                     m_status,
    output logic                                    m_granted,
    output logic                                    m_released
);

    localparam int PW = $clog2(MAX_PROCESSES);
    localparam int NW = $clog2(MAX_PROCESSES + 1);
    localparam int RW = $clog2(MAX_RESOURCES + 1);
    localparam int WW = COUNT_WIDTH + NW;

    typedef logic [MAX_RESOURCES-1:0][COUNT_WIDTH-1:0] row_t;
    typedef logic [MAX_RESOURCES-1:0][WW-1:0]          work_t;

    // item registers
    func_t                  func_reg;
    logic [PROC_W-1:0]      proc_reg;
    logic [RES_W-1:0]       res_reg;
    logic [COUNT_WIDTH-1:0] va_reg;
    logic [COUNT_WIDTH-1:0] vb_reg;
    row_t                   req_in;
    row_t                   req_reg;

    // state
    row_t                   avail_reg;
    logic [MAX_PROCESSES-1:0] active_reg;
    logic [MAX_PROCESSES-1:0] row_valid_reg;
    row_t                   alloc_mem [MAX_PROCESSES];
    row_t                   need_mem  [MAX_PROCESSES];
    row_t                   rd_alloc_reg;
    row_t                   rd_need_reg;
    logic                   rd_valid_reg;
    row_t                   hold_alloc_reg;
    row_t                   hold_need_reg;

    // scan
    work_t                  work_reg;
    logic [MAX_PROCESSES-1:0] done_reg;
    logic [NW-1:0]          scan_ptr_reg;

    // result
    status_t                res_status_reg;
    logic                   res_granted_reg;
    logic                   res_released_reg;
    logic                   m_tvalid_reg;
    status_t                m_status_reg;
    logic                   m_granted_reg;
    logic                   m_released_reg;

    logic [NW-1:0]          n_cnt;
    logic [RW-1:0]          r_cnt;
    logic [MAX_RESOURCES-1:0] lane_on;
    logic [PW-1:0]          proc_row;
    logic [PW-1:0]          mem_raddr;
    logic                   mem_we;
    row_t                   wr_alloc;
    row_t                   wr_need;
    row_t                   tnt_alloc;
    row_t                   tnt_need;
    row_t                   avail_rel;
    row_t                   rd_alloc_m;
    row_t                   rd_need_m;
    logic                   proc_ok;
    logic                   res_ok;
    logic                   proc_active;
    logic [COUNT_WIDTH-1:0] sel_avail;
    logic [COUNT_WIDTH-1:0] sel_alloc;
    logic [COUNT_WIDTH:0]   load_sum;
    logic [COUNT_WIDTH-1:0] load_base;
    logic                   load_ok;
    logic                   over_need;
    logic                   over_avail;
    logic                   req_go;
    logic                   tnt_zero;
    logic                   safe;
    logic                   release_now;
    logic                   fits;
    status_t                exec_status;

    // ---- register clamping
    always_comb begin
        if (process_count == '0) begin
            n_cnt = NW'(1);
        end else if (int'(process_count) > MAX_PROCESSES) begin
            n_cnt = NW'(MAX_PROCESSES);
        end else begin
            n_cnt = NW'(process_count);
        end
        if (resource_count == '0) begin
            r_cnt = RW'(1);
        end else if (int'(resource_count) > MAX_RESOURCES) begin
            r_cnt = RW'(MAX_RESOURCES);
        end else begin
            r_cnt = RW'(resource_count);
        end
        for (int k = 0; k < MAX_RESOURCES; k++) begin
            lane_on[k] = (k < int'(r_cnt));
        end
    end

    // ---- item capture
    for (genvar k = 0; k < MAX_RESOURCES; k++) begin : g_req
        if (k < REQ_FIELDS) begin : g_field
            assign req_in[k] = COUNT_WIDTH'(s_req[k]);
        end else begin : g_zero
            assign req_in[k] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= func_t'(s_func);
            proc_reg <= s_process;
            res_reg  <= s_resource;
            va_reg   <= COUNT_WIDTH'(s_value_a);
            vb_reg   <= COUNT_WIDTH'(s_value_b);
            req_reg  <= req_in;
        end
    end

    assign proc_row    = PW'(proc_reg);
    assign proc_ok     = int'(proc_reg) < int'(n_cnt);
    assign res_ok      = int'(res_reg) < int'(r_cnt);
    assign proc_active = proc_ok && active_reg[proc_row];

    // ---- row memories
    assign mem_raddr = cmd.scan_rd ? scan_ptr_reg[PW-1:0] : proc_row;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            alloc_mem[proc_row] <= wr_alloc;
            need_mem[proc_row]  <= wr_need;
        end
        rd_alloc_reg <= alloc_mem[mem_raddr];
        rd_need_reg  <= need_mem[mem_raddr];
        rd_valid_reg <= row_valid_reg[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (mem_we) begin
            row_valid_reg[proc_row] <= 1'b1;
        end
    end

    assign rd_alloc_m = rd_valid_reg ? rd_alloc_reg : '0;
    assign rd_need_m  = rd_valid_reg ? rd_need_reg  : '0;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            hold_alloc_reg <= rd_alloc_m;
            hold_need_reg  <= rd_need_m;
        end
    end

    // ---- operation decode
    always_comb begin
        sel_avail = '0;
        sel_alloc = '0;
        for (int k = 0; k < MAX_RESOURCES; k++) begin
            if (int'(res_reg) == k) begin
                sel_avail = avail_reg[k];
                sel_alloc = hold_alloc_reg[k];
            end
        end
    end

    assign load_sum  = {1'b0, sel_avail} + {1'b0, sel_alloc};
    assign load_base = load_sum[COUNT_WIDTH] ? '1 : load_sum[COUNT_WIDTH-1:0];
    assign load_ok   = proc_ok && res_ok && (va_reg <= load_base) && (vb_reg >= va_reg);

    always_comb begin
        logic [COUNT_WIDTH:0] sum_v;
        over_need  = 1'b0;
        over_avail = 1'b0;
        tnt_zero   = 1'b1;
        for (int k = 0; k < MAX_RESOURCES; k++) begin
            tnt_alloc[k] = hold_alloc_reg[k];
            tnt_need[k]  = hold_need_reg[k];
            if (lane_on[k]) begin
                if (req_reg[k] > hold_need_reg[k]) over_need = 1'b1;
                if (req_reg[k] > avail_reg[k]) over_avail = 1'b1;
                tnt_alloc[k] = hold_alloc_reg[k] + req_reg[k];
                tnt_need[k]  = hold_need_reg[k] - req_reg[k];
                if (tnt_need[k] != '0) tnt_zero = 1'b0;
            end
            sum_v        = {1'b0, avail_reg[k]} + {1'b0, tnt_alloc[k]};
            avail_rel[k] = sum_v[COUNT_WIDTH] ? '1 : sum_v[COUNT_WIDTH-1:0];
        end
    end

    assign req_go      = (func_reg == FUNC_REQUEST) && proc_active && !over_need && !over_avail;
    assign safe        = &done_reg;
    assign release_now = safe && tnt_zero;

    always_comb begin
        unique case (func_reg)
            FUNC_SET_TOTAL: exec_status = res_ok ? ST_OK : ST_LOAD_REJ;
            FUNC_LOAD:      exec_status = load_ok ? ST_OK : ST_LOAD_REJ;
            FUNC_REQUEST: begin
                if (!proc_active) begin
                    exec_status = ST_INACTIVE;
                end else if (over_need) begin
                    exec_status = ST_OVER_NEED;
                end else if (over_avail) begin
                    exec_status = ST_OVER_AVAIL;
                end else begin
                    exec_status = ST_OK;
                end
            end
            FUNC_RSVD:      exec_status = ST_LOAD_REJ;
            default:        exec_status = ST_LOAD_REJ;
        endcase
    end

    // ---- row write port
    always_comb begin
        mem_we   = 1'b0;
        wr_alloc = hold_alloc_reg;
        wr_need  = hold_need_reg;
        if (cmd.exec) begin
            if (func_reg == FUNC_LOAD && load_ok) begin
                mem_we = 1'b1;
                for (int k = 0; k < MAX_RESOURCES; k++) begin
                    if (int'(res_reg) == k) begin
                        wr_alloc[k] = va_reg;
                        wr_need[k]  = vb_reg - va_reg;
                    end
                end
            end else if (req_go) begin
                mem_we   = 1'b1;
                wr_alloc = tnt_alloc;
                wr_need  = tnt_need;
            end
        end else if (cmd.commit) begin
            if (!safe) begin
                mem_we = 1'b1;  // roll back to the held row
            end else if (release_now) begin
                mem_we  = 1'b1;
                wr_need = tnt_need;
                for (int k = 0; k < MAX_RESOURCES; k++) begin
                    wr_alloc[k] = lane_on[k] ? '0 : tnt_alloc[k];
                end
            end
        end
    end

    // ---- available counts and active mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avail_reg  <= '0;
            active_reg <= '0;
        end else if (cmd.exec) begin
            unique case (func_reg)
                FUNC_SET_TOTAL: begin
                    for (int k = 0; k < MAX_RESOURCES; k++) begin
                        if (res_ok && int'(res_reg) == k) avail_reg[k] <= va_reg;
                    end
                end
                FUNC_LOAD: begin
                    if (load_ok) begin
                        active_reg[proc_row] <= 1'b1;
                        for (int k = 0; k < MAX_RESOURCES; k++) begin
                            if (int'(res_reg) == k) avail_reg[k] <= load_base - va_reg;
                        end
                    end
                end
                FUNC_REQUEST: begin
                    if (req_go) begin
                        for (int k = 0; k < MAX_RESOURCES; k++) begin
                            if (lane_on[k]) avail_reg[k] <= avail_reg[k] - req_reg[k];
                        end
                    end
                end
                default: ;
            endcase
        end else if (cmd.commit) begin
            if (!safe) begin
                for (int k = 0; k < MAX_RESOURCES; k++) begin
                    if (lane_on[k]) avail_reg[k] <= avail_reg[k] + req_reg[k];
                end
            end else if (release_now) begin
                active_reg[proc_row] <= 1'b0;
                for (int k = 0; k < MAX_RESOURCES; k++) begin
                    if (lane_on[k]) avail_reg[k] <= avail_rel[k];
                end
            end
        end
    end

    // ---- safety scan: one row per check, restart from row 0 after a finish
    always_comb begin
        fits = 1'b1;
        for (int k = 0; k < MAX_RESOURCES; k++) begin
            if (lane_on[k] && (WW'(rd_need_m[k]) > work_reg[k])) fits = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_ptr_reg <= '0;
            done_reg     <= '0;
        end else if (cmd.scan_init) begin
            scan_ptr_reg <= '0;
            for (int p = 0; p < MAX_PROCESSES; p++) begin
                done_reg[p] <= !(active_reg[p] && (p < int'(n_cnt)));
            end
        end else if (cmd.scan_step) begin
            scan_ptr_reg <= scan_ptr_reg + NW'(1);
        end else if (cmd.scan_ev) begin
            if (fits) begin
                done_reg[scan_ptr_reg[PW-1:0]] <= 1'b1;
                scan_ptr_reg <= '0;
            end else begin
                scan_ptr_reg <= scan_ptr_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            for (int k = 0; k < MAX_RESOURCES; k++) begin
                work_reg[k] <= WW'(avail_reg[k]);
            end
        end else if (cmd.scan_ev && fits) begin
            for (int k = 0; k < MAX_RESOURCES; k++) begin
                if (lane_on[k]) work_reg[k] <= work_reg[k] + WW'(rd_alloc_m[k]);
            end
        end
    end

    // ---- result
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg   <= exec_status;
            res_granted_reg  <= 1'b0;
            res_released_reg <= 1'b0;
        end else if (cmd.commit) begin
            res_status_reg   <= safe ? ST_OK : ST_UNSAFE;
            res_granted_reg  <= safe;
            res_released_reg <= release_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_status_reg   <= res_status_reg;
            m_granted_reg  <= res_granted_reg;
            m_released_reg <= res_released_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_status   = m_status_reg;
    assign m_granted  = m_granted_reg;
    assign m_released = m_released_reg;

    assign stat.scan_go   = req_go;
    assign stat.scan_end  = (scan_ptr_reg == n_cnt);
    assign stat.scan_skip = done_reg[scan_ptr_reg[PW-1:0]];
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    `BSRG_ASSERT(a_load_when_free, cmd.load_result |-> (!m_tvalid_reg || m_tready))
    `BSRG_ASSERT(a_scan_ptr_range, cmd.scan_ev |-> (scan_ptr_reg < n_cnt))
    `BSRG_ASSERT_ALWAYS(a_result_flags, m_tvalid_reg |-> ((!m_released_reg || m_granted_reg) && (!m_granted_reg || m_status_reg == ST_OK)))

endmodule

`default_nettype wire

// File: rtl/core/bankers_safe_resource_grant_unit.sv
// ----------------------------------------------------------------------------
// Banker's safe resource grant unit - top level
// Deadlock-avoidance engine: set totals, load claims, grant safe requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per operation; tuser carries the operation code,
//   tdata the process, resource, values and request vector.
//   m_ channel: one result item per input item (status, granted, released).
//   cfg channel: always ready; index 0 process count, index 1 resource count.
//   Write it only while no item is in flight.
// Sequence: set total, load and rejected requests go from accept through
//   fetch, latch and execute to the result register and m_tvalid. An
//   admitted request adds the safety scan: a row still to check is read
//   from the row memory, then compared and added; a finished row is skipped,
//   and the scan restarts at row 0 after each finish.
// Throughput: one item at a time; s_tready is high only between items.
//   A result waiting in the output register does not block the next accept;
//   the next result waits until the receiver takes the earlier one.
// Reset: aresetn (sync, active low) clears counts, active mask and the row
//   memory valid bits; register defaults are 16 processes and 4 resources.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_safe_resource_grant_unit
    import bsrg_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // process[3:0] resource[5:4] value_a[21:6] value_b[37:22] req_0[53:38]
    // req_1[69:54] req_2[85:70] req_3[101:86], zero pad [103:102]
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // func[1:0]
    input  wire logic [S_TUSER_W-1:0]   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // status[2:0] granted[3] released[4], zero pad [7:5]
    output logic [M_TDATA_W-1:0]        m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [PCOUNT_W-1:0]              process_count_reg;
    logic [RCOUNT_W-1:0]              resource_count_reg;
    logic [REQ_FIELDS-1:0][FIELD_W-1:0] s_req;
    logic [STATUS_W-1:0]              m_status;
    logic                             m_granted;
    logic                             m_released;
    ctrl_cmd_t                        cmd;
    dp_stat_t                         stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            process_count_reg  <= PCOUNT_RESET;
            resource_count_reg <= RCOUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PROCESS_COUNT:  process_count_reg  <= cfg_data[PCOUNT_W-1:0];
                CFG_RESOURCE_COUNT: resource_count_reg <= cfg_data[RCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_req[0] = s_tdata[53:38];
    assign s_req[1] = s_tdata[69:54];
    assign s_req[2] = s_tdata[85:70];
    assign s_req[3] = s_tdata[101:86];

    assign m_tdata = {3'b000, m_released, m_granted, m_status};

    bsrg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsrg_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .process_count  (process_count_reg),
        .resource_count (resource_count_reg),
        .s_func         (s_tuser[FUNC_W-1:0]),
        .s_process      (s_tdata[3:0]),
        .s_resource     (s_tdata[5:4]),
        .s_value_a      (s_tdata[21:6]),
        .s_value_b      (s_tdata[37:22]),
        .s_req          (s_req),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_status       (m_status),
        .m_granted      (m_granted),
        .m_released     (m_released)
    );

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the banker's safe resource grant unit
// Sends set-total, load and request items through the input stream. It predicts
// each result from its own copy of the available, allocation and need tables
// and checks every result item in order. Both stream sides stall at random,
// and the counts are changed between phases, their limits and the clamped
// values among them.
// ----------------------------------------------------------------------------

module tb;
    import bsrg_pkg::*;

    localparam int NPROC          = MAX_PROCESSES_DEF;
    localparam int NRES           = MAX_RESOURCES_DEF;
    localparam int CMAX           = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int ITEM_TARGET    = 1100;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 600;

    typedef logic [COUNT_WIDTH_DEF-1:0] count_t;

    typedef struct packed {
        func_t                     func;
        logic [PROC_W-1:0]         proc;
        logic [RES_W-1:0]          res;
        logic [FIELD_W-1:0]        va;
        logic [FIELD_W-1:0]        vb;
        logic [REQ_FIELDS-1:0][FIELD_W-1:0] req;
    } op_t;

    typedef struct packed {
        status_t status;
        logic    granted;
        logic    released;
    } outcome_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // mirror of the block's tables and registers
    count_t              avail_cnt [NRES];
    count_t              alloc_cnt [NPROC][NRES];
    count_t              need_cnt  [NPROC][NRES];
    logic [NPROC-1:0]    active_procs;
    logic [PCOUNT_W-1:0] pcount_reg;
    logic [RCOUNT_W-1:0] rcount_reg;

    outcome_t pending_outcomes [$];
    int       items_sent  = 0;
    int       results_seen = 0;
    int       mismatches  = 0;
    int       idle_cycles = 0;
    int       total_cap   = 12;
    bit       no_gaps     = 1'b0;
    bit       rx_hold_req = 1'b0;

    bankers_safe_resource_grant_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic int proc_limit();
        if (pcount_reg == 0) return 1;
        if (int'(pcount_reg) > NPROC) return NPROC;
        return int'(pcount_reg);
    endfunction

    function automatic int res_limit();
        if (rcount_reg == 0) return 1;
        if (int'(rcount_reg) > NRES) return NRES;
        return int'(rcount_reg);
    endfunction

    function automatic count_t sat_sum(count_t a, count_t b);
        logic [COUNT_WIDTH_DEF:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH_DEF] ? count_t'(CMAX) : s[COUNT_WIDTH_DEF-1:0];
    endfunction

    // every active process must be able to finish; restart at row 0 after each
    function automatic bit state_is_safe(int n, int r);
        logic [31:0] work [NRES];
        bit          done [NPROC];
        bit          fits;
        int          p;
        for (int k = 0; k < r; k++) work[k] = 32'(avail_cnt[k]);
        for (int i = 0; i < n; i++) done[i] = !active_procs[i];
        p = 0;
        while (p < n) begin
            fits = !done[p];
            for (int k = 0; k < r; k++)
                if (32'(need_cnt[p][k]) > work[k]) fits = 1'b0;
            if (fits) begin
                done[p] = 1'b1;
                for (int k = 0; k < r; k++) work[k] += 32'(alloc_cnt[p][k]);
                p = 0;
            end else begin
                p++;
            end
        end
        for (int i = 0; i < n; i++)
            if (!done[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic outcome_t bank_step(op_t op);
        outcome_t o;
        int       n;
        int       r;
        count_t   base;
        count_t   req_v [NRES];
        bit       over_need;
        bit       over_avail;
        bit       need_clear;
        n = proc_limit();
        r = res_limit();
        o.status = ST_OK;
        o.granted = 1'b0;
        o.released = 1'b0;
        over_need = 1'b0;
        over_avail = 1'b0;
        need_clear = 1'b1;
        for (int k = 0; k < NRES; k++) req_v[k] = (k < r) ? op.req[k] : '0;
        case (op.func)
            FUNC_SET_TOTAL: begin
                if (int'(op.res) < r) avail_cnt[op.res] = op.va;
                else o.status = ST_LOAD_REJ;
            end
            FUNC_LOAD: begin
                if (int'(op.proc) >= n || int'(op.res) >= r) begin
                    o.status = ST_LOAD_REJ;
                end else begin
                    base = sat_sum(avail_cnt[op.res], alloc_cnt[op.proc][op.res]);
                    if (op.va > base || op.vb < op.va) begin
                        o.status = ST_LOAD_REJ;
                    end else begin
                        avail_cnt[op.res] = base - op.va;
                        alloc_cnt[op.proc][op.res] = op.va;
                        need_cnt[op.proc][op.res] = op.vb - op.va;
                        active_procs[op.proc] = 1'b1;
                    end
                end
            end
            FUNC_REQUEST: begin
                if (int'(op.proc) >= n || !active_procs[op.proc]) begin
                    o.status = ST_INACTIVE;
                end else begin
                    for (int k = 0; k < r; k++) begin
                        if (req_v[k] > need_cnt[op.proc][k]) over_need = 1'b1;
                        if (req_v[k] > avail_cnt[k]) over_avail = 1'b1;
                    end
                    if (over_need) begin
                        o.status = ST_OVER_NEED;
                    end else if (over_avail) begin
                        o.status = ST_OVER_AVAIL;
                    end else begin
                        for (int k = 0; k < r; k++) begin
                            need_cnt[op.proc][k] -= req_v[k];
                            alloc_cnt[op.proc][k] += req_v[k];
                            avail_cnt[k] -= req_v[k];
                        end
                        if (state_is_safe(n, r)) begin
                            o.granted = 1'b1;
                            for (int k = 0; k < r; k++)
                                if (need_cnt[op.proc][k] != '0) need_clear = 1'b0;
                            if (need_clear) begin
                                for (int k = 0; k < r; k++) begin
                                    avail_cnt[k] = sat_sum(avail_cnt[k], alloc_cnt[op.proc][k]);
                                    alloc_cnt[op.proc][k] = '0;
                                end
                                active_procs[op.proc] = 1'b0;
                                o.released = 1'b1;
                            end
                        end else begin
                            for (int k = 0; k < r; k++) begin
                                need_cnt[op.proc][k] += req_v[k];
                                alloc_cnt[op.proc][k] -= req_v[k];
                                avail_cnt[k] += req_v[k];
                            end
                            o.status = ST_UNSAFE;
                        end
                    end
                end
            end
            default: o.status = ST_LOAD_REJ;
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic op_t mk_op(func_t f, int p, int k, int va, int vb,
                                  int q0, int q1, int q2, int q3);
        op_t op;
        op = '0;
        op.func = f;
        op.proc = PROC_W'(p);
        op.res = RES_W'(k);
        op.va = FIELD_W'(va);
        op.vb = FIELD_W'(vb);
        op.req[0] = FIELD_W'(q0);
        op.req[1] = FIELD_W'(q1);
        op.req[2] = FIELD_W'(q2);
        op.req[3] = FIELD_W'(q3);
        return op;
    endfunction

    function automatic int rand_count();
        return $urandom_range(1) ? $urandom_range(CMAX) : $urandom_range(20);
    endfunction

    function automatic op_t mk_noise();
        return mk_op(func_t'($urandom_range(3)), $urandom_range(NPROC - 1),
                     $urandom_range(NRES - 1), rand_count(), rand_count(),
                     rand_count(), rand_count(), rand_count(), rand_count());
    endfunction

    function automatic op_t mk_set_total(int k);
        return mk_op(FUNC_SET_TOTAL, $urandom_range(NPROC - 1), k,
                     $urandom_range(total_cap), $urandom_range(CMAX), 0, 0, 0, 0);
    endfunction

    function automatic op_t mk_load(int p, int k);
        count_t base;
        int     va;
        int     vb;
        base = sat_sum(avail_cnt[k], alloc_cnt[p][k]);
        va = ($urandom_range(99) < 15) ? int'(base) : $urandom_range(int'(base) / 2);
        vb = va + $urandom_range(total_cap);
        if (vb > CMAX) vb = CMAX;
        return mk_op(FUNC_LOAD, p, k, va, vb, 0, 0, 0, 0);
    endfunction

    // a request for an active process, mostly within need and available; a load if none is active
    function automatic op_t mk_request();
        int     n;
        int     r;
        int     cand [$];
        int     p;
        int     sel;
        count_t lim;
        op_t    op;
        n = proc_limit();
        r = res_limit();
        for (int i = 0; i < n; i++)
            if (active_procs[i]) cand.push_back(i);
        if (cand.size() == 0)
            return mk_load($urandom_range(n - 1), $urandom_range(r - 1));
        p = cand[$urandom_range(cand.size() - 1)];
        op = mk_op(FUNC_REQUEST, p, $urandom_range(NRES - 1), rand_count(),
                   rand_count(), 0, 0, 0, 0);
        for (int k = 0; k < NRES; k++) begin
            if (k >= r) begin
                op.req[k] = $urandom_range(1) ? count_t'($urandom_range(CMAX)) : '0;
            end else begin
                lim = (need_cnt[p][k] < avail_cnt[k]) ? need_cnt[p][k] : avail_cnt[k];
                sel = $urandom_range(99);
                if (sel < 4 && need_cnt[p][k] != count_t'(CMAX))
                    op.req[k] = need_cnt[p][k] + count_t'(1);
                else if (sel < 8 && avail_cnt[k] != count_t'(CMAX))
                    op.req[k] = avail_cnt[k] + count_t'(1);
                else if (sel < 45) op.req[k] = lim;
                else op.req[k] = count_t'($urandom_range(int'(lim)));
            end
        end
        return op;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int sel;
        if (no_gaps) return 0;
        sel = $urandom_range(99);
        if (sel < 60) return 0;
        if (sel < 94) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    task automatic offer_item(input op_t op);
        repeat (pick_gap()) @(negedge aclk);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op.func;
        s_tdata  <= {2'b00, op.req, op.vb, op.va, op.res, op.proc};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        pending_outcomes.push_back(bank_step(op));
        items_sent++;
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        if (idx == CFG_PROCESS_COUNT) pcount_reg = value[PCOUNT_W-1:0];
        else if (idx == CFG_RESOURCE_COUNT) rcount_reg = value[RCOUNT_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // totals, a full load of every row, then mostly well-formed requests
    task automatic run_session(input int pc_raw, input int rc_raw, input int count,
                               input int cap);
        int n;
        int r;
        int sel;
        write_reg(CFG_PROCESS_COUNT, CFG_DATA_W'(pc_raw));
        write_reg(CFG_RESOURCE_COUNT, CFG_DATA_W'(rc_raw));
        total_cap = cap;
        n = proc_limit();
        r = res_limit();
        for (int k = 0; k < r; k++) offer_item(mk_set_total(k));
        for (int p = 0; p < n; p++)
            for (int k = 0; k < r; k++) offer_item(mk_load(p, k));
        repeat (count) begin
            sel = $urandom_range(99);
            if (sel < 70) offer_item(mk_request());
            else if (sel < 80) offer_item(mk_load($urandom_range(n - 1), $urandom_range(r - 1)));
            else if (sel < 84) offer_item(mk_set_total($urandom_range(r - 1)));
            else offer_item(mk_noise());
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        offer_item(mk_op(FUNC_REQUEST, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_RSVD, 15, 3, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        offer_item(mk_op(FUNC_SET_TOTAL, 0, 0, CMAX, 0, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_SET_TOTAL, 0, 1, 10, 0, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_LOAD, 0, 0, CMAX, CMAX, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_SET_TOTAL, 0, 0, CMAX, 0, 0, 0, 0, 0));
        // finishing request, release saturates the available count
        offer_item(mk_op(FUNC_REQUEST, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_LOAD, 1, 1, 11, 20, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_LOAD, 1, 1, 5, 4, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_LOAD, 1, 1, 4, 10, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_REQUEST, 1, 0, 0, 0, 0, 7, 0, 0));
        offer_item(mk_op(FUNC_SET_TOTAL, 0, 1, 2, 0, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_REQUEST, 1, 0, 0, 0, 0, 3, 0, 0));
        offer_item(mk_op(FUNC_LOAD, 15, 3, 0, CMAX, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_REQUEST, 15, 0, 0, 0, 0, 0, 0, CMAX));
        offer_item(mk_op(FUNC_SET_TOTAL, 0, 3, CMAX, 0, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_SET_TOTAL, 0, 2, 4, 0, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_LOAD, 2, 2, 2, 6, 0, 0, 0, 0));
        offer_item(mk_op(FUNC_LOAD, 3, 2, 1, 4, 0, 0, 0, 0));
        // no ordering lets rows 2 and 3 finish
        offer_item(mk_op(FUNC_REQUEST, 3, 0, 0, 0, 0, 0, 1, 0));
        offer_item(mk_op(FUNC_REQUEST, 1, 0, 0, 0, 0, 2, 0, 0));
        offer_item(mk_op(FUNC_REQUEST, 15, 0, 0, 0, 0, 0, 0, CMAX));
    endtask

    task automatic test_count_limits();
        run_session(1, 1, 60, 8);
        run_session(0, 0, 40, 8);
        run_session(31, 7, 60, 10);
        run_session(NPROC, NRES, 80, 12);
    endtask

    task automatic test_result_backpressure();
        rx_hold_req = 1'b1;
        repeat (6) offer_item(mk_request());
        wait_drain();
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        run_session(8, 3, 60, 10);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_traffic();
        while (items_sent < ITEM_TARGET)
            run_session($urandom_range(NPROC, 2), $urandom_range(NRES, 1), 90,
                        ($urandom_range(4) == 0) ? CMAX : $urandom_range(20, 4));
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        pcount_reg   = PCOUNT_RESET;
        rcount_reg   = RCOUNT_RESET;
        active_procs = '0;
        for (int k = 0; k < NRES; k++) begin
            avail_cnt[k] = '0;
            for (int p = 0; p < NPROC; p++) begin
                alloc_cnt[p][k] = '0;
                need_cnt[p][k] = '0;
            end
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_count_limits();
        test_result_backpressure();
        test_back_to_back();
        test_random_traffic();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int len;
        m_tready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                for (int i = 0; i < RX_HOLD_CYCLES; i++) @(negedge aclk);
                rx_hold_req = 1'b0;
                m_tready <= 1'b1;
            end else begin
                len = pick_gap();
                if (len == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (len) @(negedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic report_mismatch(input string field, input int expv, input int gotv);
        if (mismatches < 200)
            $display("tb: %s mismatch on result %0d: expected %0d, got %0d",
                     field, results_seen, expv, gotv);
        mismatches++;
    endtask

    always @(posedge aclk) begin : result_check
        outcome_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected item", 0, int'(m_tdata));
            end else begin
                due = pending_outcomes.pop_front();
                if (m_tdata[2:0] !== due.status)
                    report_mismatch("status", int'(due.status), int'(m_tdata[2:0]));
                if (m_tdata[3] !== due.granted)
                    report_mismatch("granted", int'(due.granted), int'(m_tdata[3]));
                if (m_tdata[4] !== due.released)
                    report_mismatch("released", int'(due.released), int'(m_tdata[4]));
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/bsrg_pkg.sv
rtl/core/bsrg_ctrl.sv
rtl/core/bsrg_datapath.sv
rtl/core/bankers_safe_resource_grant_unit.sv
dv/tb.sv
